@@ hw/rtl/pca_pkg.sv @@
// Types, constants and helpers for the pressure compensation and averaging unit.
package pca_pkg;

  localparam int COEF_W     = 16;  // coefficient register width
  localparam int ADC_W      = 10;  // raw conversion width
  localparam int RES_W      = 15;  // result width, 1/16 hPa
  localparam int ACC_W      = 48;  // shift-add accumulator, holds f24*325 + bias
  localparam int M_SHIFT    = 19;  // scaled value M = acc >>> M_SHIFT
  localparam int M_W        = ACC_W - M_SHIFT;
  localparam int M_DIV_W    = 24;  // in-range M fits this many bits
  localparam int MAC_STEPS  = ADC_W;
  localparam int PDIV_STEPS = 14;  // quotient bits of M / 1023
  localparam int DIVR_W     = 10;  // divisor register width
  localparam int REM_W      = DIVR_W + 1;

  localparam int OUT_LOW_HPA16  = 8000;
  localparam int OUT_HIGH_HPA16 = 18400;

  // f24 * 10400 / 2^24 == (f24 * 325) / 2^19; rounding bias 1023 * 2^18
  localparam logic [ADC_W-1:0]  SCALE_K    = ADC_W'(325);
  localparam logic [ACC_W-1:0]  ROUND_BIAS = ACC_W'(64'd1023 << 18);
  localparam logic [DIVR_W-1:0] PDIVISOR   = DIVR_W'(1023);
  // smallest M whose quotient exceeds 10400: 10401 * 1023
  localparam logic [M_W-1:0]    M_LIMIT    = M_W'(10640223);

  typedef enum logic [1:0] {
    CFG_OFFSET,
    CFG_P_SLOPE,
    CFG_T_SLOPE,
    CFG_CROSS
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_CT,
    ST_LOAD_UP,
    ST_MUL_UP,
    ST_MUL_BT,
    ST_LOAD_K,
    ST_MUL_K,
    ST_RANGE,
    ST_DIV_P,
    ST_ACCUM,
    ST_DIV_MEAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic mac_en;
    logic div_en;
    logic out_load;
  } ctl_t;

  function automatic logic signed [ACC_W-1:0] coef_ext(input logic [COEF_W-1:0] c);
    return {{(ACC_W-COEF_W){c[COEF_W-1]}}, c};
  endfunction

endpackage

@@ hw/rtl/pressure_compensate_average_unit.sv @@
// Barometric pressure compensation, per-sample saturation and windowed mean.
//
//   channel  ports                                          dir  handshake
//   -------  ---------------------------------------------  ---  ----------------
//   input    in_pressure_adc, in_temp_adc                   in   in_valid/in_stall
//   result   out_pressure_sixteenths_hpa, out_clipped       out  out_valid/out_stall
//   config   cfg_index, cfg_wdata                           in   cfg_we
//
// Each sample runs four 10-step bit-serial shift-add passes on one 48-bit accumulator
// plus a 14-step restoring divide by 1023, which a saturating sample skips. A new
// sample is taken only after the last one is done. The window's last sample also
// runs the serial divide by SAMPLES_PER_MEAN.
// Reset is synchronous, active low; it clears coefficients, window state and out_valid.
// A waiting result holds in the output register; new samples are taken meanwhile, and
// only a second window end waits in ST_OUT until the register frees up.
module pressure_compensate_average_unit
  import pca_pkg::*;
#(
  parameter int SAMPLES_PER_MEAN = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADC_W-1:0]  in_pressure_adc,
  input  logic [ADC_W-1:0]  in_temp_adc,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RES_W-1:0]  out_pressure_sixteenths_hpa,
  output logic              out_clipped
);

  localparam int HALF   = SAMPLES_PER_MEAN / 2;
  // running sum is kept biased by HALF so the mean rounds without an extra add
  localparam int SUM_W  = $clog2(SAMPLES_PER_MEAN * OUT_HIGH_HPA16 + HALF + 1);
  localparam int CNT_W  = $clog2(SAMPLES_PER_MEAN + 1);
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [SUM_W-1:0]  SUM_BIAS     = SUM_W'(HALF);
  localparam logic [CNT_W-1:0]  CNT_LAST     = CNT_W'(SAMPLES_PER_MEAN - 1);
  localparam logic [DIVR_W-1:0] MEAN_DIVISOR = DIVR_W'(SAMPLES_PER_MEAN);
  localparam logic [STEP_W-1:0] MAC_LAST     = STEP_W'(MAC_STEPS - 1);
  localparam logic [STEP_W-1:0] PDIV_LAST    = STEP_W'(PDIV_STEPS - 1);
  localparam logic [STEP_W-1:0] MDIV_LAST    = STEP_W'(SUM_W - 1);
  localparam logic [RES_W-1:0]  OUT_LOW      = RES_W'(OUT_LOW_HPA16);
  localparam logic [RES_W-1:0]  OUT_HIGH     = RES_W'(OUT_HIGH_HPA16);

  state_t state_r, state_nxt;
  ctl_t   ctl;

  // coefficient registers
  logic [COEF_W-1:0] offset_r, p_slope_r, t_slope_r, cross_r;

  // sample operands
  logic [ADC_W-1:0] p_r, p_nxt, t_r, t_nxt;

  // serial shift-add unit
  logic signed [ACC_W-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt, mac_sum;
  logic [ADC_W-1:0]        mplier_r, mplier_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;

  // serial restoring divider, shared by the 1023 scaling and the mean
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_sh;
  logic [REM_W:0]    rem_diff;
  logic              borrow;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [DIVR_W-1:0] divisor_r, divisor_nxt;

  // range check of the scaled value
  logic [M_W-1:0] m_val;
  logic           m_neg, m_high;
  logic           samp_low_r, samp_low_nxt, samp_high_r, samp_high_nxt;
  logic [RES_W-1:0] sample_val;

  // window state
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             clip_seen_r, clip_seen_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [RES_W-1:0] out_res_r, out_res_nxt;
  logic             out_clip_r, out_clip_nxt;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_MUL_CT;
      ST_MUL_CT:   if (step_r == MAC_LAST) state_nxt = ST_LOAD_UP;
      ST_LOAD_UP:  state_nxt = ST_MUL_UP;
      ST_MUL_UP:   if (step_r == MAC_LAST) state_nxt = ST_MUL_BT;
      ST_MUL_BT:   if (step_r == MAC_LAST) state_nxt = ST_LOAD_K;
      ST_LOAD_K:   state_nxt = ST_MUL_K;
      ST_MUL_K:    if (step_r == MAC_LAST) state_nxt = ST_RANGE;
      ST_RANGE:    state_nxt = (m_neg || m_high) ? ST_ACCUM : ST_DIV_P;
      ST_DIV_P:    if (step_r == PDIV_LAST) state_nxt = ST_ACCUM;
      ST_ACCUM:    state_nxt = (cnt_r == CNT_LAST) ? ST_DIV_MEAN : ST_IDLE;
      ST_DIV_MEAN: if (step_r == MDIV_LAST) state_nxt = ST_OUT;
      ST_OUT:      if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- decode
  always_comb begin
    ctl.in_ready = (state_r == ST_IDLE);
    ctl.mac_en   = state_r inside {ST_MUL_CT, ST_MUL_UP, ST_MUL_BT, ST_MUL_K};
    ctl.div_en   = state_r inside {ST_DIV_P, ST_DIV_MEAN};
    ctl.out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  // ---------------------------------------------------------------- datapath
  assign mac_sum  = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign rem_sh   = {rem_r[REM_W-2:0], dvd_r[SUM_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, divisor_r};
  assign borrow   = rem_diff[REM_W];

  // M = floor((f24*325 + 1023*2^18) / 2^19); sample = floor(M / 1023) + 8000
  assign m_val  = acc_r[ACC_W-1:M_SHIFT];
  assign m_neg  = m_val[M_W-1];
  assign m_high = !m_neg && (m_val >= M_LIMIT);

  assign sample_val = samp_low_r  ? OUT_LOW  :
                      samp_high_r ? OUT_HIGH :
                      RES_W'(quo_r[PDIV_STEPS-1:0]) + OUT_LOW;
  assign sum_add    = sum_r + SUM_W'(sample_val);

  always_comb begin
    p_nxt         = p_r;
    t_nxt         = t_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    divisor_nxt   = divisor_r;
    samp_low_nxt  = samp_low_r;
    samp_high_nxt = samp_high_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    clip_seen_nxt = clip_seen_r;
    out_res_nxt   = out_res_r;
    out_clip_nxt  = out_clip_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (ctl.mac_en) begin
      acc_nxt    = mac_sum;
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      step_nxt   = (step_r == MAC_LAST) ? '0 : step_r + 1'b1;
    end

    if (ctl.div_en) begin
      rem_nxt  = borrow ? rem_sh : rem_diff[REM_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], !borrow};
      dvd_nxt  = dvd_r << 1;
      step_nxt = step_r + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // pass 1: c12 * T
          p_nxt      = in_pressure_adc;
          t_nxt      = in_temp_adc;
          acc_nxt    = '0;
          mcand_nxt  = coef_ext(cross_r);
          mplier_nxt = in_temp_adc;
          step_nxt   = '0;
        end
      end
      ST_LOAD_UP: begin
        // pass 2: a0*2^21 + (b1*2^11 + c12*T) * P
        mcand_nxt  = acc_r + (coef_ext(p_slope_r) <<< 11);
        acc_nxt    = coef_ext(offset_r) <<< 21;
        mplier_nxt = p_r;
      end
      ST_MUL_UP: begin
        if (step_r == MAC_LAST) begin
          // pass 3: + b2*2^10 * T, accumulating on
          mcand_nxt  = coef_ext(t_slope_r) <<< 10;
          mplier_nxt = t_r;
        end
      end
      ST_LOAD_K: begin
        // pass 4: f24 * 325 + rounding bias
        mcand_nxt  = acc_r;
        acc_nxt    = ROUND_BIAS;
        mplier_nxt = SCALE_K;
      end
      ST_RANGE: begin
        samp_low_nxt  = m_neg;
        samp_high_nxt = m_high;
        if (m_neg || m_high) clip_seen_nxt = 1'b1;
        // in range M < 2^24 and M >> 14 stays below 1023, so it seeds the remainder
        rem_nxt     = REM_W'(m_val[M_DIV_W-1:PDIV_STEPS]);
        dvd_nxt     = SUM_W'(m_val[PDIV_STEPS-1:0]) << (SUM_W - PDIV_STEPS);
        quo_nxt     = '0;
        divisor_nxt = PDIVISOR;
        step_nxt    = '0;
      end
      ST_ACCUM: begin
        if (cnt_r == CNT_LAST) begin
          cnt_nxt     = '0;
          sum_nxt     = SUM_BIAS;
          rem_nxt     = '0;
          dvd_nxt     = sum_add;
          quo_nxt     = '0;
          divisor_nxt = MEAN_DIVISOR;
          step_nxt    = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          sum_nxt = sum_add;
        end
      end
      ST_OUT: begin
        if (ctl.out_load) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = quo_r[RES_W-1:0];
          out_clip_nxt  = clip_seen_r;
          clip_seen_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= '0;
      p_slope_r   <= '0;
      t_slope_r   <= '0;
      cross_r     <= '0;
      sum_r       <= SUM_BIAS;
      cnt_r       <= '0;
      clip_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      clip_seen_r <= clip_seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OFFSET:  offset_r  <= cfg_wdata;
          CFG_P_SLOPE: p_slope_r <= cfg_wdata;
          CFG_T_SLOPE: t_slope_r <= cfg_wdata;
          CFG_CROSS:   cross_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    t_r         <= t_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    step_r      <= step_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    quo_r       <= quo_nxt;
    divisor_r   <= divisor_nxt;
    samp_low_r  <= samp_low_nxt;
    samp_high_r <= samp_high_nxt;
    out_res_r   <= out_res_nxt;
    out_clip_r  <= out_clip_nxt;
  end

  assign in_stall                    = !ctl.in_ready;
  assign out_valid                   = out_valid_r;
  assign out_pressure_sixteenths_hpa = out_res_r;
  assign out_clipped                 = out_clip_r;

endmodule
